### src/gsl_pkg.sv
// ---------------------------------------------------------------------------
// gsl_pkg: shared types and constants for the gate status decoder
// Sample and result structs, indicator classes, status codes, register map.
// ---------------------------------------------------------------------------
package gsl_pkg;

	typedef enum logic [1:0] {
		CLS_OFF   = 2'd0,
		CLS_BLINK = 2'd1,
		CLS_ON    = 2'd2
	} class_t;

	typedef enum logic [2:0] {
		ST_CLOSED      = 3'd0,
		ST_OPENED      = 3'd1,
		ST_OPENING     = 3'd2,
		ST_CLOSING     = 3'd3,
		ST_STOPPED     = 3'd4,
		ST_ERROR       = 3'd5,
		ST_OBSTRUCTION = 3'd6
	} status_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        green_lit;
		logic        red_lit;
	} sample_t;

	typedef struct packed {
		logic [2:0] gate_status;
		logic [1:0] green_class;
		logic [1:0] red_class;
	} result_t;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register select is the word bit of paddr
	localparam logic REG_BLINK_WINDOW = 1'b0;
	localparam logic REG_OBST_LIMIT   = 1'b1;

	localparam logic [15:0] RST_BLINK_WINDOW = 16'd1000;
	localparam logic [23:0] RST_OBST_LIMIT   = 24'd20000;

endpackage

### src/gsl_lane.sv
// ---------------------------------------------------------------------------
// gsl_lane: one indicator classifier
// Tracks the last rising edge of an indicator and classes it off/blink/on.
// ---------------------------------------------------------------------------
module gsl_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [31:0]          now_ms,
	input  logic                 level,
	input  logic [15:0]          blink_window_ms,
	output gsl_pkg::class_t      cls
);
	import gsl_pkg::*;

	logic [31:0] edge_time_q;
	logic        prev_level_q;
	logic [31:0] elapsed;

	// class uses the edge time held before this sample
	assign elapsed = now_ms - edge_time_q;

	always_comb begin
		if (elapsed < {16'd0, blink_window_ms}) begin
			cls = CLS_BLINK;
		end else if (level) begin
			cls = CLS_ON;
		end else begin
			cls = CLS_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_time_q  <= '0;
			prev_level_q <= 1'b0;
		end else if (accept) begin
			if (level && !prev_level_q) begin
				edge_time_q <= now_ms;
			end
			prev_level_q <= level;
		end
	end

endmodule

### src/gsl_merge.sv
// ---------------------------------------------------------------------------
// gsl_merge: status decode from the two lane classes
// Decodes the class pair and tracks how long closing has lasted.
// ---------------------------------------------------------------------------
module gsl_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [31:0]          now_ms,
	input  gsl_pkg::class_t      green_cls,
	input  gsl_pkg::class_t      red_cls,
	input  logic [23:0]          obstruction_limit_ms,
	output gsl_pkg::status_t     status
);
	import gsl_pkg::*;

	status_t     base;
	logic        closing_active_q;
	logic [31:0] closing_start_q;
	logic [31:0] closing_time;
	logic        overdue;

	always_comb begin
		if (green_cls == CLS_OFF && red_cls == CLS_ON) begin
			base = ST_CLOSED;
		end else if (green_cls == CLS_ON && red_cls == CLS_OFF) begin
			base = ST_OPENED;
		end else if (green_cls == CLS_BLINK && red_cls == CLS_OFF) begin
			base = ST_OPENING;
		end else if (green_cls == CLS_OFF && red_cls == CLS_BLINK) begin
			base = ST_CLOSING;
		end else if (green_cls == CLS_BLINK && red_cls == CLS_BLINK) begin
			base = ST_STOPPED;
		end else begin
			base = ST_ERROR;
		end
	end

	// on a fresh closing start the active flag is still low, so never past the limit
	assign closing_time = now_ms - closing_start_q;
	assign overdue      = closing_active_q && (closing_time > {8'd0, obstruction_limit_ms});
	assign status       = (base == ST_CLOSING && overdue) ? ST_OBSTRUCTION : base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closing_active_q <= 1'b0;
			closing_start_q  <= '0;
		end else if (accept) begin
			if (base == ST_CLOSING) begin
				if (!closing_active_q) begin
					closing_start_q  <= now_ms;
					closing_active_q <= 1'b1;
				end
			end else begin
				closing_active_q <= 1'b0;
				closing_start_q  <= '0;
			end
		end
	end

endmodule

### src/gsl_out_buf.sv
// ---------------------------------------------------------------------------
// gsl_out_buf: two-entry result buffer
// Output register plus skid entry; full only when both are occupied.
// ---------------------------------------------------------------------------
module gsl_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  gsl_pkg::result_t     push_data,
	output logic                 full,
	output logic                 valid,
	input  logic                 stall,
	output gsl_pkg::result_t     data
);
	import gsl_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop   = main_valid_q && !stall;
	assign full  = skid_valid_q;
	assign valid = main_valid_q;
	assign data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

### src/gate_status_from_led_blink.sv
// ---------------------------------------------------------------------------
// gate_status_from_led_blink: gate status from two indicator lamps
// Classes a green and a red lamp as off, on or blinking and decodes the
// pair into a gate status, with obstruction detection on long closing.
// ---------------------------------------------------------------------------
// Usage:
//   sample channel  : sample_valid / sample_stall / sample (now_ms + levels).
//                     A transfer takes place when valid is high, stall low.
//   status channel  : status_valid / status_stall / status, one result for
//                     every sample transfer, in order.
//   APB port        : blink window at 0x0, obstruction limit at 0x4.
//                     Write only while the block is idle.
// Result: registered at its sample transfer. Throughput: one sample per
//   cycle unless the buffer is full; the two lamp lanes and the status
//   decode all settle combinationally between transfer and result
//   register, so back-to-back samples flow without bubbles.
// Stall: a two-entry result buffer (output register + skid entry) holds
//   results while the receiver stalls; sample_stall rises only once both
//   entries are full, so a sample can still be taken after a stall begins.
// Reset: edge times, previous levels and closing tracking clear to zero,
//   buffer empties, registers return to 1000 ms and 20000 ms.
// ---------------------------------------------------------------------------
module gate_status_from_led_blink (
	input  logic                         clk,
	input  logic                         arst_n,
	// sample channel
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  gsl_pkg::sample_t             sample,
	// status channel
	output logic                         status_valid,
	input  logic                         status_stall,
	output gsl_pkg::result_t             status,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gsl_pkg::PADDR_W-1:0]  paddr,
	input  logic [gsl_pkg::PDATA_W-1:0]  pwdata,
	output logic [gsl_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import gsl_pkg::*;

	logic [15:0] blink_window_q;
	logic [23:0] obst_limit_q;
	logic        cfg_write;
	logic        accept;
	class_t      green_cls;
	class_t      red_cls;
	status_t     gate_st;
	result_t     result;
	logic        buf_full;

	// ---- configuration registers ------------------------------------------
	// Only the word bit of paddr selects a register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_window_q <= RST_BLINK_WINDOW;
			obst_limit_q   <= RST_OBST_LIMIT;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_BLINK_WINDOW: blink_window_q <= pwdata[15:0];
				REG_OBST_LIMIT:   obst_limit_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BLINK_WINDOW: prdata = {16'd0, blink_window_q};
			REG_OBST_LIMIT:   prdata = {8'd0, obst_limit_q};
			default:          prdata = '0;
		endcase
	end

	// ---- sample transfer ----------------------------------------------------
	assign sample_stall = buf_full;
	assign accept       = sample_valid && !buf_full;

	// ---- lamp lanes: one classifier per indicator, side by side -------------
	gsl_lane u_green (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.now_ms          (sample.now_ms),
		.level           (sample.green_lit),
		.blink_window_ms (blink_window_q),
		.cls             (green_cls)
	);

	gsl_lane u_red (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.now_ms          (sample.now_ms),
		.level           (sample.red_lit),
		.blink_window_ms (blink_window_q),
		.cls             (red_cls)
	);

	// ---- merge: class pair to gate status, closing timer --------------------
	gsl_merge u_merge (
		.clk                  (clk),
		.arst_n               (arst_n),
		.accept               (accept),
		.now_ms               (sample.now_ms),
		.green_cls            (green_cls),
		.red_cls              (red_cls),
		.obstruction_limit_ms (obst_limit_q),
		.status               (gate_st)
	);

	always_comb begin
		result.gate_status = gate_st;
		result.green_class = green_cls;
		result.red_class   = red_cls;
	end

	// ---- result buffer --------------------------------------------------------
	gsl_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (buf_full),
		.valid     (status_valid),
		.stall     (status_stall),
		.data      (status)
	);

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for gate_status_from_led_blink
// Drives lamp samples through the valid/stall sample channel, predicts every
// status transfer with a cycle-free model of the lamp classifier and status
// decoder held in a scoreboard, and checks results in order. Runs a short
// directed sequence, then random phases over several register settings with
// sender gaps, receiver stalls and one long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;

	import gsl_pkg::*;

	// lamp waveform used to build well-formed random sequences
	typedef enum {PAT_DARK, PAT_FLASH, PAT_STEADY} lamp_pattern_t;

	// -----------------------------------------------------------------------
	// Scoreboard: own copy of the registers and the lamp/closing state,
	// one expected result queued per accepted sample.
	// -----------------------------------------------------------------------
	class gate_scoreboard;
		logic [15:0] blink_window;
		logic [23:0] obst_limit;
		logic [31:0] green_edge_ms;
		logic [31:0] red_edge_ms;
		logic [31:0] closing_since;
		logic        green_prev;
		logic        red_prev;
		logic        closing_on;
		result_t     expected_q[$];
		int          failures;

		function new();
			blink_window  = 16'd1000;
			obst_limit    = 24'd20000;
			green_edge_ms = '0;
			red_edge_ms   = '0;
			closing_since = '0;
			green_prev    = 1'b0;
			red_prev      = 1'b0;
			closing_on    = 1'b0;
			failures      = 0;
		endfunction

		// register write as seen by the block: upper bits dropped
		function void write_reg(logic sel, logic [31:0] data);
			if (sel == REG_BLINK_WINDOW) begin
				blink_window = data[15:0];
			end else begin
				obst_limit = data[23:0];
			end
		endfunction

		// class from the edge time held before this sample
		function class_t lamp_class(logic [31:0] now, logic [31:0] edge_ms, logic level);
			logic [31:0] since;
			since = now - edge_ms;
			if (since < {16'd0, blink_window}) begin
				return CLS_BLINK;
			end else if (level) begin
				return CLS_ON;
			end
			return CLS_OFF;
		endfunction

		function void note_sample(sample_t s);
			class_t      g;
			class_t      r;
			status_t     st;
			result_t     res;
			g = lamp_class(s.now_ms, green_edge_ms, s.green_lit);
			if (s.green_lit && !green_prev) begin
				green_edge_ms = s.now_ms;
			end
			green_prev = s.green_lit;
			r = lamp_class(s.now_ms, red_edge_ms, s.red_lit);
			if (s.red_lit && !red_prev) begin
				red_edge_ms = s.now_ms;
			end
			red_prev = s.red_lit;

			if (g == CLS_OFF && r == CLS_ON) begin
				st = ST_CLOSED;
			end else if (g == CLS_ON && r == CLS_OFF) begin
				st = ST_OPENED;
			end else if (g == CLS_BLINK && r == CLS_OFF) begin
				st = ST_OPENING;
			end else if (g == CLS_OFF && r == CLS_BLINK) begin
				st = ST_CLOSING;
			end else if (g == CLS_BLINK && r == CLS_BLINK) begin
				st = ST_STOPPED;
			end else begin
				st = ST_ERROR;
			end

			// closing start time of zero is still a live start time
			if (st == ST_CLOSING) begin
				if (!closing_on) begin
					closing_since = s.now_ms;
					closing_on    = 1'b1;
				end
			end else begin
				closing_on    = 1'b0;
				closing_since = '0;
			end
			if (closing_on && (s.now_ms - closing_since) > {8'd0, obst_limit}) begin
				st = ST_OBSTRUCTION;
			end

			res.gate_status = st;
			res.green_class = g;
			res.red_class   = r;
			expected_q.push_back(res);
		endfunction

		function void check_status(result_t got);
			result_t exp;
			if (expected_q.size() == 0) begin
				$error("status transfer with no sample outstanding: %h", got);
				failures++;
				return;
			end
			exp = expected_q.pop_front();
			if (got.gate_status !== exp.gate_status) begin
				$error("gate_status: expected %0d, got %0d", exp.gate_status, got.gate_status);
				failures++;
			end
			if (got.green_class !== exp.green_class) begin
				$error("green_class: expected %0d, got %0d", exp.green_class, got.green_class);
				failures++;
			end
			if (got.red_class !== exp.red_class) begin
				$error("red_class: expected %0d, got %0d", exp.red_class, got.red_class);
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// Block connections
	// -----------------------------------------------------------------------
	logic                clk;
	logic                arst_n;
	logic                sample_valid;
	logic                sample_stall;
	sample_t             sample;
	logic                status_valid;
	logic                status_stall;
	result_t             status;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	gate_status_from_led_blink DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.status_valid (status_valid),
		.status_stall (status_stall),
		.status       (status),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	gate_scoreboard status_board = new();

	// running lamp clock for well-formed sequences; wraps freely
	logic [31:0] lamp_time;
	// per-phase odds (out of 100) of a sender gap / receiver stall cycle
	int          send_gap_pct;
	int          stall_pct;
	// long hold-off requests from the main sequence, served by the receiver
	int          hold_requests;
	int          holds_done;
	int          hold_left;

	// -----------------------------------------------------------------------
	// Clock and run limit
	// -----------------------------------------------------------------------
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// generous ceiling: several times the slowest legal run
	initial begin
		#(8 * 500000);
		$display("Some tests failed");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Receiver: random stalls, or a long counted hold-off when asked.
	// During the hold the sender keeps offering, so the two-entry result
	// buffer fills and sample_stall must rise.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			status_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_requests != holds_done) begin
			holds_done = holds_done + 1;
			hold_left  = 300;
			status_stall <= 1'b1;
		end else begin
			status_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: transfers are judged on pre-edge values at each rising edge.
	// A result can never belong to a sample taken at the same edge, so the
	// order of the two calls does not matter.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				status_board.note_sample(sample);
			end
			if (status_valid && !status_stall) begin
				status_board.check_status(status);
			end
		end
	end

	// -----------------------------------------------------------------------
	// Drivers
	// -----------------------------------------------------------------------

	// one sample transfer; gaps drawn before it, payload held while stalled
	task automatic drive_lamps(input logic [31:0] now, input logic g, input logic r);
		while ($urandom_range(99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid     <= 1'b1;
		sample.now_ms    <= now;
		sample.green_lit <= g;
		sample.red_lit   <= r;
		do @(posedge clk); while (sample_stall);
	endtask

	// stop offering and wait until every expected status has come back
	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (status_board.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic reg_write(input logic sel, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		status_board.write_reg(sel, data);
	endtask

	function automatic logic pattern_level(lamp_pattern_t p, int idx, logic start);
		case (p)
			PAT_DARK:   return 1'b0;
			PAT_STEADY: return 1'b1;
			default:    return start ^ idx[0];
		endcase
	endfunction

	// Mostly coherent lamp sequences on an advancing clock, with steps
	// scaled to the blink window so flashing lamps stay in the window;
	// the rest is free noise and odd glitches within sequences.
	task automatic run_random(input int n_items);
		int            sent;
		int            seq_len;
		int            max_step;
		lamp_pattern_t green_pat;
		lamp_pattern_t red_pat;
		logic          green_start;
		logic          red_start;
		logic          g;
		logic          r;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 15) begin
				drive_lamps($urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
				sent++;
			end else begin
				// lean towards the closing pattern so obstruction gets reached
				if ($urandom_range(99) < 30) begin
					green_pat = PAT_DARK;
					red_pat   = PAT_FLASH;
				end else begin
					green_pat = lamp_pattern_t'($urandom_range(2));
					red_pat   = lamp_pattern_t'($urandom_range(2));
				end
				green_start = 1'($urandom_range(1));
				red_start   = 1'($urandom_range(1));
				seq_len     = $urandom_range(60, 4);
				if ($urandom_range(99) < 6) begin
					lamp_time = 32'hFFFF_FFFF - $urandom_range(3000);
				end else if ($urandom_range(99) < 5) begin
					lamp_time = $urandom();
				end
				max_step = (status_board.blink_window > 16'd9) ?
				           status_board.blink_window / 3 : 3;
				for (int i = 0; i < seq_len && sent < n_items; i++) begin
					lamp_time = lamp_time + $urandom_range(max_step, 1);
					g = pattern_level(green_pat, i, green_start);
					r = pattern_level(red_pat, i, red_start);
					if ($urandom_range(24) == 0) g = ~g;
					if ($urandom_range(24) == 0) r = ~r;
					drive_lamps(lamp_time, g, r);
					sent++;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [31:0] window_word, input logic [31:0] limit_word,
	                         input int gap, input int stall, input int n_items,
	                         input bit long_hold);
		drain();
		reg_write(REG_BLINK_WINDOW, window_word);
		reg_write(REG_OBST_LIMIT, limit_word);
		send_gap_pct = gap;
		stall_pct    = stall;
		if (long_hold) begin
			hold_requests = hold_requests + 1;
		end
		run_random(n_items);
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n        <= 1'b0;
		sample_valid  <= 1'b0;
		sample        <= '0;
		status_stall  <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		lamp_time     = '0;
		send_gap_pct  = 0;
		stall_pct     = 0;
		hold_requests = 0;
		holds_done    = 0;
		hold_left     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings. Edge times start at zero, so both lamps read as
		// blinking below the window; then on/off decodes, fresh edges,
		// a closing run and a wrap of the millisecond counter.
		drive_lamps(32'd0,          1'b0, 1'b0);
		drive_lamps(32'd999,        1'b0, 1'b0);
		drive_lamps(32'd1000,       1'b0, 1'b0);
		drive_lamps(32'd1500,       1'b1, 1'b1);
		drive_lamps(32'd1600,       1'b1, 1'b1);
		drive_lamps(32'd2600,       1'b1, 1'b0);
		drive_lamps(32'd3000,       1'b0, 1'b1);
		drive_lamps(32'd3100,       1'b0, 1'b1);
		drive_lamps(32'd3200,       1'b0, 1'b0);
		drive_lamps(32'd3500,       1'b1, 1'b0);
		drive_lamps(32'hFFFF_FFFF,  1'b1, 1'b1);
		drive_lamps(32'd499,        1'b0, 1'b1);
		drive_lamps(32'd2000,       1'b0, 1'b0);

		// Short obstruction limit: closing begins exactly at time zero
		// (red edge just before the wrap) and must still turn into
		// obstruction rather than restart.
		drain();
		reg_write(REG_OBST_LIMIT, 32'd100);
		drive_lamps(32'd4000,       1'b0, 1'b0);
		drive_lamps(32'd5000,       1'b1, 1'b0);
		drive_lamps(32'hFFFF_FF00,  1'b0, 1'b1);
		drive_lamps(32'd0,          1'b0, 1'b1);
		drive_lamps(32'd50,         1'b0, 1'b0);
		drive_lamps(32'd120,        1'b0, 1'b1);
		drive_lamps(32'd700,        1'b0, 1'b0);
		drive_lamps(32'd1300,       1'b0, 1'b0);

		// Random phases: reset values, then extremes (upper bits written
		// to check masking; a zero window from a masked write), then
		// short windows/limits that reach obstruction often.
		run_phase(32'd1000,      32'd20000,     0,  0,  120, 1'b0);
		run_phase(32'hFFFF_FFFF, 32'd0,         68, 0,  100, 1'b0);
		run_phase(32'd1,         32'hFFFF_FFFF, 0,  68, 80,  1'b0);
		run_phase(32'h0001_0000, 32'd300,       30, 30, 60,  1'b0);
		run_phase(32'd300,       32'd1200,      0,  0,  150, 1'b1);
		run_phase(32'd5000,      32'hFF00_0BB8, 30, 30, 100, 1'b0);

		// wait for the last results, then idle to catch strays
		drain();
		repeat (10) @(posedge clk);
		if (status_board.failures == 0 && status_board.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
